>>> design/rme_pkg.sv
// Package: shared types, widths and constants for the modular exponentiation unit
`timescale 1ns / 1ps
package rme_pkg;

   localparam int SYMBOL_WIDTH = 32;
   localparam int RESULT_WIDTH = 33;
   localparam int STATUS_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [RESULT_WIDTH-1:0] SYM_OFFSET = 33'd97;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_MODULUS   = 2'd0,
      CSR_EXPONENT  = 2'd1,
      CSR_DIRECTION = 2'd2
   } csr_index_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_ZERO_MOD  = 2'd1,
      STATUS_LOW_INPUT = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_SQUARE,
      ST_MULT,
      ST_DONE
   } state_type;

   localparam logic DIR_ENCRYPT = 1'b0;
   localparam logic DIR_DECRYPT = 1'b1;

endpackage

>>> design/rme_if.sv
// Interfaces: request and response channels with valid/ready handshake
`timescale 1ns / 1ps
interface rme_req_if import rme_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [SYMBOL_WIDTH-1:0] symbol_value;

   modport source (output valid, output symbol_value, input ready);
   modport sink (input valid, input symbol_value, output ready);
endinterface

interface rme_rsp_if import rme_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [RESULT_WIDTH-1:0] result_value;
   logic [STATUS_WIDTH-1:0] status;

   modport source (output valid, output result_value, output status, input ready);
   modport sink (input valid, input result_value, input status, output ready);
endinterface

>>> design/rme_mod_mul.sv
// Bit-serial modular multiplier: one bit of b per cycle, double-and-add with reduction
`timescale 1ns / 1ps
module rme_mod_mul #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] a,
   input  logic [WIDTH-1:0] b,
   input  logic [WIDTH-1:0] m,
   output logic             done,
   output logic [WIDTH-1:0] product
);

   localparam int CW = $clog2(WIDTH);

   logic [WIDTH-1:0] a_ff, b_ff, m_ff, r_ff;
   logic [WIDTH-1:0] a_in, b_in, m_in, r_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [WIDTH:0]   dbl, dbl_red, sum, sum_red;
   logic [WIDTH-1:0] addend, r_step;

   always_comb begin
      dbl = {r_ff, 1'b0};
      if (dbl >= {1'b0, m_ff}) begin
         dbl_red = dbl - {1'b0, m_ff};
      end else begin
         dbl_red = dbl;
      end
      addend = b_ff[WIDTH-1] ? a_ff : '0;
      sum = {1'b0, dbl_red[WIDTH-1:0]} + {1'b0, addend};
      if (sum >= {1'b0, m_ff}) begin
         sum_red = sum - {1'b0, m_ff};
      end else begin
         sum_red = sum;
      end
      r_step = sum_red[WIDTH-1:0];
   end

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      m_in = m_ff;
      r_in = r_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in = a;
         b_in = b;
         m_in = m;
         r_in = '0;
         cnt_in = CW'(WIDTH - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         r_in = r_step;
         b_in = {b_ff[WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      m_ff <= m_in;
      r_ff <= r_in;
   end

   assign done = done_ff;
   assign product = r_ff;

endmodule

>>> design/rsa_modular_exponentiation_unit.sv
// Top level: left-to-right square-and-multiply over a bit-serial modular multiplier
// Sequence: error items and zero exponent go straight to the result; otherwise the base is
// reduced first, then one square per exponent bit and a multiply per set bit, up to
// 2*WORD_WIDTH of them, on one multiplier; the result is then registered.
// Throughput: one item at a time; the next item is taken once the result is registered.
// Reset: synchronous, active high; modulus 0, exponent 1, direction encrypt.
`timescale 1ns / 1ps
module rsa_modular_exponentiation_unit import rme_pkg::*; #(
   parameter int WORD_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   rme_req_if.sink                    req_ch,
   rme_rsp_if.source                  rsp_ch
);

   localparam int WW = WORD_WIDTH;
   localparam int CW = $clog2(WW);
   localparam logic [WW-1:0] OFFSET_W = WW'(SYM_OFFSET);

   logic [WW-1:0] modulus_ff, exponent_ff;
   logic          direction_ff;

   state_type     state_ff, state_in;
   logic [WW-1:0] base_ff, base_in;
   logic [WW-1:0] exp_ff, exp_in;
   logic [CW-1:0] bit_cnt_ff, bit_cnt_in;
   logic [RESULT_WIDTH-1:0] res_ff, res_in;
   status_type    status_ff, status_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [RESULT_WIDTH-1:0] rsp_result_ff, rsp_result_in;
   logic [STATUS_WIDTH-1:0] rsp_status_ff, rsp_status_in;

   logic          mm_start, mm_done;
   logic [WW-1:0] mm_a, mm_b, mm_product;

   logic [WW+CSR_DATA_WIDTH-1:0] csr_ext, sym_ext;
   logic [WW-1:0] csr_w, sym_w, one_mod, base_pre;
   logic [WW+RESULT_WIDTH-1:0] fin_ext, unit_ext;
   logic          accept, sym_low, exp_last, out_free;

   assign csr_ext = {{WW{1'b0}}, csr_write_data};
   assign csr_w = csr_ext[WW-1:0];
   assign sym_ext = {{WW{1'b0}}, req_ch.symbol_value};
   assign sym_w = sym_ext[WW-1:0];

   assign accept = req_ch.valid && (state_ff == ST_IDLE);
   assign sym_low = (direction_ff == DIR_ENCRYPT) && (sym_w < OFFSET_W);
   assign base_pre = (direction_ff == DIR_ENCRYPT) ? (sym_w - OFFSET_W) : sym_w;
   assign one_mod = (modulus_ff == WW'(1)) ? '0 : WW'(1);
   assign exp_last = (bit_cnt_ff == '0);
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   assign fin_ext = (WW+RESULT_WIDTH)'(mm_product)
                    + ((direction_ff == DIR_DECRYPT) ? (WW+RESULT_WIDTH)'(SYM_OFFSET) : '0);
   assign unit_ext = (WW+RESULT_WIDTH)'(1)
                     + ((direction_ff == DIR_DECRYPT) ? (WW+RESULT_WIDTH)'(SYM_OFFSET) : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= '0;
         exponent_ff <= WW'(1);
         direction_ff <= DIR_ENCRYPT;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MODULUS: modulus_ff <= csr_w;
            CSR_EXPONENT: exponent_ff <= csr_w;
            CSR_DIRECTION: direction_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (modulus_ff == '0 || sym_low || exponent_ff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (mm_done) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (mm_done) begin
               if (exp_ff[WW-1]) begin
                  state_in = ST_MULT;
               end else if (exp_last) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_MULT: begin
            if (mm_done) begin
               state_in = exp_last ? ST_DONE : ST_SQUARE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      base_in = base_ff;
      exp_in = exp_ff;
      bit_cnt_in = bit_cnt_ff;
      res_in = res_ff;
      status_in = status_ff;
      mm_start = 1'b0;
      mm_a = mm_product;
      mm_b = mm_product;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_result_in = rsp_result_ff;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               exp_in = exponent_ff;
               bit_cnt_in = CW'(WW - 1);
               res_in = '0;
               status_in = STATUS_OK;
               if (modulus_ff == '0) begin
                  status_in = STATUS_ZERO_MOD;
               end else if (sym_low) begin
                  status_in = STATUS_LOW_INPUT;
               end else if (exponent_ff == '0) begin
                  res_in = unit_ext[RESULT_WIDTH-1:0];
               end else begin
                  mm_start = 1'b1;
                  mm_a = WW'(1);
                  mm_b = base_pre;
               end
            end
         end
         ST_REDUCE: begin
            if (mm_done) begin
               base_in = mm_product;
               mm_start = 1'b1;
               mm_a = one_mod;
               mm_b = one_mod;
            end
         end
         ST_SQUARE: begin
            if (mm_done) begin
               if (exp_ff[WW-1]) begin
                  mm_start = 1'b1;
                  mm_b = base_ff;
               end else if (exp_last) begin
                  res_in = fin_ext[RESULT_WIDTH-1:0];
               end else begin
                  exp_in = {exp_ff[WW-2:0], 1'b0};
                  bit_cnt_in = bit_cnt_ff - 1'b1;
                  mm_start = 1'b1;
               end
            end
         end
         ST_MULT: begin
            if (mm_done) begin
               if (exp_last) begin
                  res_in = fin_ext[RESULT_WIDTH-1:0];
               end else begin
                  exp_in = {exp_ff[WW-2:0], 1'b0};
                  bit_cnt_in = bit_cnt_ff - 1'b1;
                  mm_start = 1'b1;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_result_in = res_ff;
               rsp_status_in = status_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         bit_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         bit_cnt_ff <= bit_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      exp_ff <= exp_in;
      res_ff <= res_in;
      status_ff <= status_in;
      rsp_result_ff <= rsp_result_in;
      rsp_status_ff <= rsp_status_in;
   end

   rme_mod_mul #(
      .WIDTH(WW)
   ) u_mod_mul (
      .clock(clock),
      .reset(reset),
      .start(mm_start),
      .a(mm_a),
      .b(mm_b),
      .m(modulus_ff),
      .done(mm_done),
      .product(mm_product)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.result_value = rsp_result_ff;
   assign rsp_ch.status = rsp_status_ff;

endmodule

>>> tb/sv/rsa_modular_exponentiation_unit_checker.sv
// Checker: tracks register writes, predicts each modular power and compares result items
`timescale 1ns / 1ps
module rsa_modular_exponentiation_unit_checker import rme_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   rme_req_if                         req_ch,
   rme_rsp_if                         rsp_ch,
   output int                         mismatch_count,
   output int                         outstanding_count
);

   typedef struct packed {
      logic [SYMBOL_WIDTH-1:0] symbol;
      logic [RESULT_WIDTH-1:0] value;
      status_type              status;
   } power_result_type;

   logic [SYMBOL_WIDTH-1:0] key_modulus = '0;
   logic [SYMBOL_WIDTH-1:0] key_exponent = 1;
   logic                    key_direction = DIR_ENCRYPT;
   power_result_type        awaited_powers[$];
   int                      mismatches = 0;
   int                      outstanding = 0;

   assign mismatch_count = mismatches;
   assign outstanding_count = outstanding;

   function automatic logic [SYMBOL_WIDTH-1:0] mod_power(
      input logic [SYMBOL_WIDTH-1:0] base,
      input logic [SYMBOL_WIDTH-1:0] power,
      input logic [SYMBOL_WIDTH-1:0] modulus
   );
      logic [63:0] acc;
      logic [63:0] reduced_base;
      if (power == 0) begin
         return 1;
      end
      reduced_base = 64'(base) % 64'(modulus);
      acc = 64'd1 % 64'(modulus);
      for (int i = SYMBOL_WIDTH - 1; i >= 0; i--) begin
         acc = (acc * acc) % 64'(modulus);
         if (power[i]) begin
            acc = (acc * reduced_base) % 64'(modulus);
         end
      end
      return acc[SYMBOL_WIDTH-1:0];
   endfunction

   function automatic power_result_type expected_power(input logic [SYMBOL_WIDTH-1:0] symbol);
      power_result_type outcome;
      logic [RESULT_WIDTH-1:0] shifted;
      outcome.symbol = symbol;
      outcome.value = '0;
      outcome.status = STATUS_OK;
      if (key_modulus == 0) begin
         outcome.status = STATUS_ZERO_MOD;
      end else if (key_direction == DIR_ENCRYPT) begin
         if ({1'b0, symbol} < SYM_OFFSET) begin
            outcome.status = STATUS_LOW_INPUT;
         end else begin
            shifted = {1'b0, symbol} - SYM_OFFSET;
            outcome.value = {1'b0, mod_power(shifted[SYMBOL_WIDTH-1:0], key_exponent,
                                             key_modulus)};
         end
      end else begin
         outcome.value = {1'b0, mod_power(symbol, key_exponent, key_modulus)} + SYM_OFFSET;
      end
      return outcome;
   endfunction

   always @(posedge clock) begin : watch_channels
      power_result_type want;
      if (reset) begin
         key_modulus = '0;
         key_exponent = 1;
         key_direction = DIR_ENCRYPT;
         awaited_powers.delete();
         outstanding = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            awaited_powers.push_back(expected_power(req_ch.symbol_value));
            outstanding++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_powers.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected item, expected none, actual value %h status %0d",
                        $time, rsp_ch.result_value, rsp_ch.status);
            end else begin
               want = awaited_powers.pop_front();
               outstanding--;
               if (rsp_ch.result_value !== want.value) begin
                  mismatches++;
                  $display("%0t: symbol %h result_value expected %h actual %h",
                           $time, want.symbol, want.value, rsp_ch.result_value);
               end
               if (rsp_ch.status !== want.status) begin
                  mismatches++;
                  $display("%0t: symbol %h status expected %0d actual %0d",
                           $time, want.symbol, want.status, rsp_ch.status);
               end
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_MODULUS:   key_modulus = csr_write_data[SYMBOL_WIDTH-1:0];
               CSR_EXPONENT:  key_exponent = csr_write_data[SYMBOL_WIDTH-1:0];
               CSR_DIRECTION: key_direction = csr_write_data[0];
               default: ;
            endcase
         end
      end
   end

endmodule

>>> tb/sv/rsa_modular_exponentiation_unit_tb.sv
// Testbench top: clock, reset, key writes, symbol stimulus, result back-pressure and verdict
`timescale 1ns / 1ps
module rsa_modular_exponentiation_unit_tb import rme_pkg::*; ();

   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int LONG_HOLD = 6000;
   localparam int DRAIN_CYCLES = 2200;
   localparam int RANDOM_PHASES = 13;
   localparam int PHASE_ITEMS = 20;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE = 2'd3;

   logic                       clock;
   logic                       reset;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;
   int                         mismatch_count;
   int                         outstanding_count;
   int                         cycle_count;
   int                         hold_asks = 0;
   bit                         sender_gaps = 1'b1;
   bit                         receiver_gaps = 1'b1;

   rme_req_if req_ch ();
   rme_rsp_if rsp_ch ();

   rsa_modular_exponentiation_unit dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch)
   );

   rsa_modular_exponentiation_unit_checker power_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_ch            (req_ch),
      .rsp_ch            (rsp_ch),
      .mismatch_count    (mismatch_count),
      .outstanding_count (outstanding_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("rsa_modular_exponentiation_unit_tb: errors");
      $finish;
   end

   initial begin : drive_ready
      int hold_served;
      hold_served = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else if (hold_served != hold_asks) begin
            hold_served++;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic offer_symbol(input logic [SYMBOL_WIDTH-1:0] symbol);
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.symbol_value <= symbol;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic settle_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding_count != 0) @(posedge clock);
   endtask

   task automatic apply_key(
      input logic [CSR_DATA_WIDTH-1:0] modulus,
      input logic [CSR_DATA_WIDTH-1:0] exponent,
      input logic                      direction
   );
      logic [CSR_DATA_WIDTH-1:0] direction_word;
      direction_word = $urandom;
      direction_word[0] = direction;
      csr_write_enable <= 1'b1;
      csr_index <= CSR_MODULUS;
      csr_write_data <= modulus;
      @(posedge clock);
      csr_index <= CSR_EXPONENT;
      csr_write_data <= exponent;
      @(posedge clock);
      csr_index <= CSR_DIRECTION;
      csr_write_data <= direction_word;
      @(posedge clock);
      csr_index <= CSR_SPARE;
      csr_write_data <= $urandom;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [CSR_DATA_WIDTH-1:0] pick_modulus();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 1;
         2: return 32'hFFFF_FFFF;
         3, 4: return $urandom_range(2, 65535);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [CSR_DATA_WIDTH-1:0] pick_exponent();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 1;
         2: return 32'hFFFF_FFFF;
         3, 4, 5: return $urandom_range(2, 255);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [SYMBOL_WIDTH-1:0] pick_symbol(input logic [SYMBOL_WIDTH-1:0] modulus);
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 96);
         1: return $urandom_range(97, 300);
         2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
         3: return modulus + $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   initial begin : make_stimulus
      logic [CSR_DATA_WIDTH-1:0] modulus;
      reset <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_MODULUS;
      csr_write_data <= '0;
      req_ch.valid <= 1'b0;
      req_ch.symbol_value <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      offer_symbol(32'd0);
      offer_symbol(32'hFFFF_FFFF);
      settle_results();

      apply_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, DIR_ENCRYPT);
      offer_symbol(32'd96);
      offer_symbol(32'd97);
      offer_symbol(32'd98);
      offer_symbol(32'd0);
      offer_symbol(32'h8000_0000);
      offer_symbol(32'hFFFF_FFFF);
      settle_results();

      apply_key(32'd1, 32'd0, DIR_DECRYPT);
      offer_symbol(32'd0);
      offer_symbol(32'hFFFF_FFFF);
      settle_results();

      apply_key(32'd1, 32'd5, DIR_DECRYPT);
      offer_symbol(32'd7);
      settle_results();

      apply_key(32'hFFFF_FFFB, 32'd0, DIR_ENCRYPT);
      offer_symbol(32'd97);
      offer_symbol(32'd96);
      settle_results();

      apply_key(32'd3233, 32'd17, DIR_ENCRYPT);
      offer_symbol(32'd104);
      offer_symbol(32'd200);
      offer_symbol(32'hFFFF_FFFF);
      settle_results();

      apply_key(32'd3233, 32'd2753, DIR_DECRYPT);
      offer_symbol(32'd3000);
      offer_symbol(32'd3232);
      offer_symbol(32'hFFFF_FFFF);
      settle_results();

      apply_key(32'hFFFF_FFFF, 32'd1, DIR_DECRYPT);
      offer_symbol(32'hFFFF_FFFE);
      offer_symbol(32'hFFFF_FFFF);
      settle_results();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         sender_gaps = (phase < RANDOM_PHASES - 3);
         receiver_gaps = (phase < RANDOM_PHASES - 3);
         modulus = pick_modulus();
         apply_key(modulus, pick_exponent(), 1'($urandom_range(0, 1)));
         if (phase == 2) begin
            hold_asks++;
         end
         repeat (PHASE_ITEMS) offer_symbol(pick_symbol(modulus));
         settle_results();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && outstanding_count == 0) begin
         $display("rsa_modular_exponentiation_unit_tb: clean");
      end else begin
         $display("rsa_modular_exponentiation_unit_tb: errors");
      end
      $finish;
   end

endmodule
